// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define BMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmc: implication check failed");

// Next-cycle implication.
`define BMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmc: next-cycle check failed");

`endif

// File: rtl/core/bmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int CTR_W = 10;
  localparam int REG_IDX_W = 1;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd400;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bmc_reg_e;

  typedef enum logic [1:0] {
    ST_ACCUM  = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_FINISH = 2'd2
  } bmc_state_e;

  typedef struct packed {
    logic accept_pix;
    logic start_div;
    logic div_step;
    logic load_out;
  } bmc_cmd_t;

  typedef struct packed {
    logic frame_last;
  } bmc_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/bmc_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bmc_pix_if import bmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bmc_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bmc_res_if import bmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CTR_W-1:0] center_x;
  logic [CTR_W-1:0] center_y;
  logic             region_empty;

  modport source (output valid, output center_x, output center_y, output region_empty,
                  input ready);
  modport sink   (input valid, input center_x, input center_y, input region_empty,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/bmc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bmc_ctrl import bmc_pkg::*; #(
  parameter int QN = 10
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire bmc_stat_t stat_i,
  output bmc_cmd_t       cmd_o
);

  localparam int STEP_W = $clog2(QN);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QN - 1);

  bmc_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              load_ok;

  assign load_ok = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACCUM: begin
        if (in_valid_i && stat_i.frame_last) state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (step_q == LAST_STEP) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_ok) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_ACCUM: begin
        in_ready_o       = 1'b1;
        cmd_o.accept_pix = in_valid_i;
        cmd_o.start_div  = in_valid_i && stat_i.frame_last;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.load_out = load_ok;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (cmd_o.start_div) step_d = '0;
    else if (cmd_o.div_step) step_d = step_q + STEP_W'(1);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bmc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module bmc_datapath import bmc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic [PIX_W-1:0]     pixel_value_i,
  input  wire bmc_cmd_t             cmd_i,
  output bmc_stat_t                 stat_o,
  output logic [CTR_W-1:0]          center_x_o,
  output logic [CTR_W-1:0]          center_y_o,
  output logic                      region_empty_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int SX_W  = 2 * COL_W + ROW_W;
  localparam int SY_W  = COL_W + 2 * ROW_W;
  localparam int QN    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int DV_W  = CNT_W + QN - 1;
  localparam int S_MAX = (SX_W > SY_W) ? SX_W : SY_W;
  localparam int CMP_W = (S_MAX > DV_W) ? S_MAX : DV_W;

  logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
  logic [WW-1:0]    w_eff, col_inc;
  logic [HW-1:0]    h_eff, row_inc;
  logic             col_wrap, row_wrap, pix_set;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [SX_W-1:0]  sum_x_q, sum_x_d;
  logic [SY_W-1:0]  sum_y_q, sum_y_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_add;
  logic [DV_W-1:0]  div_q, div_d;
  logic [QN-1:0]    qx_q, qx_d, qy_q, qy_d;

  logic [CMP_W-1:0] rem_x_ext, rem_y_ext, div_ext, diff_x, diff_y;
  logic             ge_x, ge_y;

  logic [CTR_W-1:0] cx_q, cy_q;
  logic             empty_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= CFG_SIZE_RESET;
      cfg_h_q <= CFG_SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (bmc_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_FRAME_HEIGHT: cfg_h_q <= cfg_data_i;
        default:          cfg_w_q <= cfg_w_q;
      endcase
    end
  end

  // zero acts as one, oversize saturates at the maximum
  always_comb begin
    if (cfg_w_q == '0) w_eff = WW'(1);
    else if (32'(cfg_w_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(cfg_w_q);

    if (cfg_h_q == '0) h_eff = HW'(1);
    else if (32'(cfg_h_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(cfg_h_q);
  end

  assign col_inc  = WW'(col_q) + WW'(1);
  assign row_inc  = HW'(row_q) + HW'(1);
  assign col_wrap = !(col_inc < w_eff);
  assign row_wrap = !(row_inc < h_eff);
  assign pix_set  = pixel_value_i != '0;

  assign stat_o.frame_last = col_wrap && row_wrap;

  assign cnt_add = pix_set ? cnt_q + CNT_W'(1) : cnt_q;

  // one restoring step per cycle for both coordinates against a shared divisor
  assign rem_x_ext = CMP_W'(sum_x_q);
  assign rem_y_ext = CMP_W'(sum_y_q);
  assign div_ext   = CMP_W'(div_q);
  assign ge_x      = rem_x_ext >= div_ext;
  assign ge_y      = rem_y_ext >= div_ext;
  assign diff_x    = rem_x_ext - div_ext;
  assign diff_y    = rem_y_ext - div_ext;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    div_d   = div_q;
    qx_d    = qx_q;
    qy_d    = qy_q;
    priority if (cmd_i.load_out) begin
      sum_x_d = '0;
      sum_y_d = '0;
      cnt_d   = '0;
    end else if (cmd_i.div_step) begin
      if (ge_x) sum_x_d = SX_W'(diff_x);
      if (ge_y) sum_y_d = SY_W'(diff_y);
      qx_d  = {qx_q[QN-2:0], ge_x};
      qy_d  = {qy_q[QN-2:0], ge_y};
      div_d = div_q >> 1;
    end else if (cmd_i.accept_pix) begin
      if (pix_set) begin
        sum_x_d = sum_x_q + SX_W'(col_q);
        sum_y_d = sum_y_q + SY_W'(row_q);
      end
      cnt_d = cnt_add;
      if (!col_wrap) begin
        col_d = col_q + COL_W'(1);
      end else begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_q + ROW_W'(1);
      end
      if (cmd_i.start_div) div_d = DV_W'(cnt_add) << (QN - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    qx_q  <= qx_d;
    qy_q  <= qy_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cnt_q == '0) begin
        cx_q    <= CTR_W'(w_eff >> 1);
        cy_q    <= CTR_W'(h_eff >> 1);
        empty_q <= 1'b1;
      end else begin
        cx_q    <= CTR_W'(qx_q);
        cy_q    <= CTR_W'(qy_q);
        empty_q <= 1'b0;
      end
    end
  end

  assign center_x_o     = cx_q;
  assign center_y_o     = cy_q;
  assign region_empty_o = empty_q;

endmodule

`default_nettype wire

// File: rtl/core/binary_mask_centroid.sv
// Centroid of the set (nonzero) pixels of a raster frame. Pixels are taken one per clock in
// raster order; column and row are tracked internally from frame_width and frame_height
// (0 reads as 1, values above MAX_WIDTH / MAX_HEIGHT saturate). After the last pixel of a
// frame, pixel_in.ready drops while a restoring divider produces one quotient bit per cycle
// for both coordinates at once (clog2(max(MAX_WIDTH, MAX_HEIGHT)) bits, 10 at the default
// size), and stays low until the result register is loaded, which waits while it still
// holds an untaken result. An empty frame reports the frame middle with region_empty set.
// The result register lets the next frame stream in while the previous result waits.
`timescale 1ns / 1ps
`default_nettype none

module binary_mask_centroid import bmc_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [REG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  bmc_pix_if.sink                   pixel_in,
  bmc_res_if.source                 result_out
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int QN    = (COL_W > ROW_W) ? COL_W : ROW_W;

  bmc_cmd_t  cmd;
  bmc_stat_t stat;

  bmc_ctrl #(
    .QN (QN)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pixel_in.valid),
    .in_ready_o  (pixel_in.ready),
    .out_valid_o (result_out.valid),
    .out_ready_i (result_out.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bmc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_value_i  (pixel_in.pixel_value),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .center_x_o     (result_out.center_x),
    .center_y_o     (result_out.center_y),
    .region_empty_o (result_out.region_empty)
  );

endmodule

`default_nettype wire

// File: rtl/core/bmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bmc_checker import bmc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [CTR_W-1:0] center_x_i,
  input wire logic [CTR_W-1:0] center_y_i,
  input wire logic             region_empty_i
);

  logic [2*CTR_W:0] out_data;

  assign out_data = {center_x_i, center_y_i, region_empty_i};

  // a held result stays until its transaction completes
  `BMC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  `BMC_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data))

  // input only stalls right after a pixel that closed a frame
  `BMC_ASSERT_IMP(a_stall_after_pixel, clk_i, rst_ni, $fell(in_ready_i), $past(in_valid_i && in_ready_i))

  // a fresh result only follows the divide phase, when no pixel is taken
  `BMC_ASSERT_IMP(a_result_after_divide, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind binary_mask_centroid bmc_checker u_bmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (pixel_in.valid),
  .in_ready_i     (pixel_in.ready),
  .out_valid_i    (result_out.valid),
  .out_ready_i    (result_out.ready),
  .center_x_i     (result_out.center_x),
  .center_y_i     (result_out.center_y),
  .region_empty_i (result_out.region_empty)
);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bmc_pkg::*;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned MAX_H         = 1024;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned IDLE_PCT      = 37;

  typedef struct packed {
    logic [CTR_W-1:0] x;
    logic [CTR_W-1:0] y;
    logic             empty;
  } centroid_t;

  // Tracks the frame position and sums as the block should, and holds the
  // centroids still owed by the block.
  class centroid_tracker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      col;
    int unsigned      row;
    longint unsigned  sum_x;
    longint unsigned  sum_y;
    longint unsigned  set_cnt;
    centroid_t        centroid_q[$];
    int unsigned      mismatches;
    int unsigned      results_seen;
    int unsigned      frames_empty;
    int unsigned      pixels_seen;
    int unsigned      size_writes;

    function new();
      width_reg    = CFG_SIZE_RESET;
      height_reg   = CFG_SIZE_RESET;
      mismatches   = 0;
      results_seen = 0;
      frames_empty = 0;
      pixels_seen  = 0;
      size_writes  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      col     = 0;
      row     = 0;
      sum_x   = 0;
      sum_y   = 0;
      set_cnt = 0;
    endfunction

    function int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return v;
    endfunction

    function int unsigned pending();
      return centroid_q.size();
    endfunction

    function void write_reg(bmc_reg_e idx, logic [CFG_W-1:0] v);
      size_writes++;
      case (idx)
        REG_FRAME_WIDTH:  width_reg  = v;
        REG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [PIX_W-1:0] p);
      int unsigned w;
      int unsigned h;
      centroid_t   c;
      w = eff_size(width_reg, MAX_W);
      h = eff_size(height_reg, MAX_H);
      pixels_seen++;
      if (p != '0) begin
        sum_x += col;
        sum_y += row;
        set_cnt++;
      end
      // a position already past a shrunk size ends the row / frame at once
      if (col + 1 < w) begin
        col++;
        return;
      end
      col = 0;
      if (row + 1 < h) begin
        row++;
        return;
      end
      if (set_cnt == 0) begin
        c.x     = CTR_W'(w / 2);
        c.y     = CTR_W'(h / 2);
        c.empty = 1'b1;
      end else begin
        c.x     = CTR_W'(sum_x / set_cnt);
        c.y     = CTR_W'(sum_y / set_cnt);
        c.empty = 1'b0;
      end
      centroid_q = {centroid_q, c};
      clear_frame();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task check_result(logic [CTR_W-1:0] x, logic [CTR_W-1:0] y, logic e);
      centroid_t want;
      if (centroid_q.size() == 0) begin
        report_mismatch($sformatf("centroid with none owed: x=%0d y=%0d empty=%0b", x, y, e));
        return;
      end
      want = centroid_q.pop_front();
      results_seen++;
      if (want.empty) frames_empty++;
      if (x !== want.x)
        report_mismatch($sformatf("frame %0d center_x %0d, want %0d", results_seen, x, want.x));
      if (y !== want.y)
        report_mismatch($sformatf("frame %0d center_y %0d, want %0d", results_seen, y, want.y));
      if (e !== want.empty)
        report_mismatch($sformatf("frame %0d region_empty %0b, want %0b", results_seen, e,
                                  want.empty));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          src_idle_pct  = IDLE_PCT;
  int unsigned          sink_idle_pct = IDLE_PCT;
  int unsigned          hold_left     = 0;

  centroid_tracker tracker = new();

  bmc_pix_if pix_if ();
  bmc_res_if res_if ();

  binary_mask_centroid #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pixel_in    (pix_if),
    .result_out  (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("binary_mask_centroid regression: fail");
    $finish;
  end

  // result side: random back-pressure, or a counted hold-off on request
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready)
        tracker.check_result(res_if.center_x, res_if.center_y, res_if.region_empty);
      if (pix_if.valid && pix_if.ready) tracker.note_pixel(pix_if.pixel_value);
      if (cfg_we) tracker.write_reg(bmc_reg_e'(cfg_index), cfg_data);
    end
  end

  // called at a falling edge; leaves valid high so back-to-back pixels stream
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid = 1'b0;
      @(negedge clk);
    end
    pix_if.valid       = 1'b1;
    pix_if.pixel_value = v;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pixels(input int unsigned count, input int unsigned density);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < density) send_pixel(PIX_W'($urandom_range(1, 255)));
      else send_pixel('0);
    end
  endtask

  task automatic write_size(input bmc_reg_e idx, input logic [CFG_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // size registers only change once every owed centroid is out
  task automatic drain_results();
    pix_if.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned      fw;
    int unsigned      fh;
    int unsigned      npix;
    int unsigned      dens;
    int unsigned      rand_px;
    logic [CFG_W-1:0] w_val;
    logic [CFG_W-1:0] h_val;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_FRAME_WIDTH;
    cfg_data           = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // a few pixels at the reset size, then shrink to 1x1 with the column past the end
    send_pixels(10, 30);
    drain_results();
    write_size(REG_FRAME_WIDTH, '0);
    write_size(REG_FRAME_HEIGHT, '0);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h01);
    drain_results();

    write_size(REG_FRAME_WIDTH, 11'd3);
    write_size(REG_FRAME_HEIGHT, 11'd2);
    repeat (6) send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h00);
    send_pixel(8'h80);
    send_pixel(8'h00);
    send_pixel(8'h7F);
    send_pixel(8'h00);
    drain_results();

    // size change part-way through a frame
    write_size(REG_FRAME_WIDTH, 11'd4);
    write_size(REG_FRAME_HEIGHT, 11'd3);
    send_pixel(8'h01);
    repeat (4) send_pixel(8'h00);
    send_pixel(8'h40);
    drain_results();
    write_size(REG_FRAME_WIDTH, 11'd2);
    write_size(REG_FRAME_HEIGHT, 11'd2);
    send_pixel(8'hFF);
    drain_results();

    // row counter already past the last row of a shrunk height
    write_size(REG_FRAME_WIDTH, 11'd2);
    write_size(REG_FRAME_HEIGHT, 11'd5);
    send_pixels(8, 50);
    drain_results();
    write_size(REG_FRAME_WIDTH, 11'd2);
    write_size(REG_FRAME_HEIGHT, 11'd2);
    send_pixels(2, 50);
    drain_results();

    // 1x1 frames against a stalled receiver: result register and divider fill up
    write_size(REG_FRAME_WIDTH, 11'd1);
    write_size(REG_FRAME_HEIGHT, 11'd1);
    src_idle_pct = 0;
    hold_left    = 300;
    send_pixels(40, 50);
    drain_results();

    // no idling on either side
    write_size(REG_FRAME_WIDTH, 11'd5);
    write_size(REG_FRAME_HEIGHT, 11'd3);
    sink_idle_pct = 0;
    send_pixels(90, 40);
    drain_results();
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;

    rand_px = 0;
    while (rand_px < 350) begin
      case ($urandom_range(19))
        0: begin
          w_val = '0;
          h_val = CFG_W'($urandom_range(1, 5));
        end
        1: begin
          w_val = CFG_W'($urandom_range(1, 6));
          h_val = '0;
        end
        2, 3, 4: begin
          w_val = CFG_W'($urandom_range(1, 24));
          h_val = CFG_W'($urandom_range(1, 6));
        end
        default: begin
          w_val = CFG_W'($urandom_range(1, 6));
          h_val = CFG_W'($urandom_range(1, 5));
        end
      endcase
      // sometimes one register keeps its old value
      if ($urandom_range(3) != 0) write_size(REG_FRAME_WIDTH, w_val);
      if ($urandom_range(3) != 0) write_size(REG_FRAME_HEIGHT, h_val);
      fw = tracker.eff_size(tracker.width_reg, MAX_W);
      fh = tracker.eff_size(tracker.height_reg, MAX_H);
      case ($urandom_range(4))
        0:       dens = 0;
        1:       dens = 100;
        2:       dens = 10;
        default: dens = 45;
      endcase
      npix = $urandom_range(1, 3) * fw * fh;
      // leave a frame half done so the next size change lands mid-frame
      if ($urandom_range(4) == 0) npix += $urandom_range(1, fw * fh);
      send_pixels(npix, dens);
      rand_px += npix;
      drain_results();
    end

    $display("checked %0d centroids (%0d of empty frames) over %0d pixels, %0d size writes",
             tracker.results_seen, tracker.frames_empty, tracker.pixels_seen,
             tracker.size_writes);
    $display("sizes: reset, zero, small random, changes mid-frame; long receiver hold-off");
    if (tracker.mismatches == 0) begin
      $display("binary_mask_centroid regression: pass");
    end else begin
      $display("binary_mask_centroid regression: fail");
    end
    $finish;
  end

endmodule
